### rtl/btha_pkg.sv
package btha_pkg;

  localparam logic [31:0] SIZE_MASK  = 32'h3FFF_FFFF;
  localparam logic [31:0] ALLOC_BIT  = 32'h4000_0000;
  localparam logic [31:0] SPLIT_MIN  = 32'd4;
  localparam logic [31:0] INIT_CHUNK = 32'(1 << 10);
  localparam logic [16:0] GROW_RESET = 17'(1 << 10);
  localparam logic [16:0] MIN_NEED   = 17'((8 + 8) / 4);

  typedef enum logic [1:0] {
    RES_DONE  = 2'd0,
    RES_NOSPC = 2'd1,
    RES_IGN   = 2'd2
  } res_t;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_DECODE, S_FIT_RD, S_FIT_EVAL, S_GROW, S_GROW_W0, S_GROW_W1,
    S_GROW_W2, S_MG0, S_MG1, S_MG2, S_MG3, S_MG4, S_PL0, S_PL1, S_PL2, S_FR0, S_FR1,
    S_SB_H, S_SB_F, S_FINISH
  } st_t;

  typedef enum logic [4:0] {
    OP_CLEAR, OP_IDLE, OP_DECODE, OP_FIT_RD, OP_FIT_EVAL, OP_GROW, OP_GROW_W0,
    OP_GROW_W1, OP_GROW_W2, OP_MG0, OP_MG1, OP_MG2, OP_MG3, OP_MG4, OP_PL0, OP_PL1,
    OP_PL2, OP_FR0, OP_FR1, OP_SB_H, OP_SB_F, OP_FINISH
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic is_alloc;
    logic ign;
    logic hdr_past;
    logic fit_fail;
    logic fit_found;
    logic grow_fail;
    logic mg_none;
    logic split;
    logic out_free;
  } sts_t;

endpackage

### rtl/btha_ctrl.sv
module btha_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  input  btha_pkg::sts_t  sts,
  output btha_pkg::cmd_t  cmd
);
  import btha_pkg::*;

  st_t st_r, st_nxt;
  st_t ret_r, ret_nxt;
  st_t mret_r, mret_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_CLEAR;
      ret_r  <= S_FINISH;
      mret_r <= S_FINISH;
    end else begin
      st_r   <= st_nxt;
      ret_r  <= ret_nxt;
      mret_r <= mret_nxt;
    end
  end

  always_comb begin
    st_nxt   = st_r;
    ret_nxt  = ret_r;
    mret_nxt = mret_r;
    cmd.op   = OP_IDLE;
    case (st_r)
      S_CLEAR: begin
        cmd.op = OP_CLEAR;
        if (sts.clr_done) st_nxt = S_IDLE;
      end
      S_IDLE: begin
        cmd.op = OP_IDLE;
        if (in_tvalid) st_nxt = S_DECODE;
      end
      S_DECODE: begin
        cmd.op = OP_DECODE;
        if (sts.ign) st_nxt = S_FINISH;
        else if (sts.is_alloc) st_nxt = S_FIT_RD;
        else st_nxt = S_FR0;
      end
      S_FIT_RD: begin
        cmd.op = OP_FIT_RD;
        st_nxt = sts.hdr_past ? S_GROW : S_FIT_EVAL;
      end
      S_FIT_EVAL: begin
        cmd.op = OP_FIT_EVAL;
        if (sts.fit_fail) st_nxt = S_GROW;
        else if (sts.fit_found) st_nxt = S_PL0;
      end
      S_GROW: begin
        cmd.op = OP_GROW;
        st_nxt = sts.grow_fail ? S_FINISH : S_GROW_W0;
      end
      S_GROW_W0: begin
        cmd.op = OP_GROW_W0;
        st_nxt = S_GROW_W1;
      end
      S_GROW_W1: begin
        cmd.op = OP_GROW_W1;
        st_nxt = S_GROW_W2;
      end
      S_GROW_W2: begin
        cmd.op   = OP_GROW_W2;
        mret_nxt = S_PL0;
        st_nxt   = S_MG0;
      end
      S_MG0: begin
        cmd.op = OP_MG0;
        st_nxt = S_MG1;
      end
      S_MG1: begin
        cmd.op = OP_MG1;
        st_nxt = S_MG2;
      end
      S_MG2: begin
        cmd.op = OP_MG2;
        st_nxt = S_MG3;
      end
      S_MG3: begin
        cmd.op = OP_MG3;
        st_nxt = S_MG4;
      end
      S_MG4: begin
        cmd.op = OP_MG4;
        if (sts.mg_none) begin
          st_nxt = mret_r;
        end else begin
          ret_nxt = mret_r;
          st_nxt  = S_SB_H;
        end
      end
      S_PL0: begin
        cmd.op = OP_PL0;
        st_nxt = S_PL1;
      end
      S_PL1: begin
        cmd.op  = OP_PL1;
        ret_nxt = sts.split ? S_PL2 : S_FINISH;
        st_nxt  = S_SB_H;
      end
      S_PL2: begin
        cmd.op  = OP_PL2;
        ret_nxt = S_FINISH;
        st_nxt  = S_SB_H;
      end
      S_FR0: begin
        cmd.op = OP_FR0;
        st_nxt = S_FR1;
      end
      S_FR1: begin
        cmd.op   = OP_FR1;
        ret_nxt  = S_MG0;
        mret_nxt = S_FINISH;
        st_nxt   = S_SB_H;
      end
      S_SB_H: begin
        cmd.op = OP_SB_H;
        st_nxt = S_SB_F;
      end
      S_SB_F: begin
        cmd.op = OP_SB_F;
        st_nxt = ret_r;
      end
      S_FINISH: begin
        cmd.op = OP_FINISH;
        if (sts.out_free) st_nxt = S_IDLE;
      end
      default: begin
        cmd.op = OP_IDLE;
        st_nxt = S_IDLE;
      end
    endcase
  end

endmodule

### rtl/btha_dp.sv
module btha_dp #(
  parameter int unsigned HEAP_WORDS = 65536
) (
  input  logic            clk,
  input  logic            rst_n,
  input  btha_pkg::cmd_t  cmd,
  input  logic            in_tvalid,
  input  logic [39:0]     in_tdata,
  input  logic            in_tuser,
  input  logic            cfg_valid,
  input  logic [16:0]     cfg_data,
  input  logic            out_tready,
  output logic            out_tvalid,
  output logic [23:0]     out_tdata,
  output btha_pkg::sts_t  sts
);
  import btha_pkg::*;

  localparam int unsigned AW = $clog2(HEAP_WORDS);
  localparam int unsigned BW = $clog2(HEAP_WORDS + 1);
  localparam logic [31:0] HEAP = 32'(HEAP_WORDS);
  localparam bit FITS = HEAP_WORDS >= 1028;
  localparam logic [BW-1:0] BP_RESET = FITS ? BW'(1028) : BW'(4);

  logic [31:0] mem [HEAP_WORDS];

  logic [AW-1:0] clr_r;
  logic [BW-1:0] bp_r;
  logic [16:0]   grow_r;
  logic          out_valid_r;
  logic [15:0]   out_pay_r;
  res_t          out_st_r;

  logic          act_r;
  logic [17:0]   req_r;
  logic [15:0]   baddr_r;
  logic [16:0]   need_r;
  logic [31:0]   hdr_r, size_r, prev_r, psize_r, have_r, sb_addr_r, sb_val_r;
  logic          pf_r;
  logic [15:0]   res_pay_r;
  res_t          res_st_r;
  logic [31:0]   q_r;
  logic          oob_r;

  logic [31:0] rdata, s, nh;
  logic        rfree, found, over;
  logic [17:0] in_req;
  logic [18:0] req15;
  logic [16:0] need_in, gw;
  logic [17:0] gw1, w;
  logic        free_bad;
  logic        rd_en, wr_en;
  logic [31:0] rd_addr, wr_addr, wr_data;

  function automatic logic [31:0] init_word(input logic [AW-1:0] a);
    logic [31:0] x;
    x = 32'(a);
    if (x == 32'd1 || x == 32'd2) return ALLOC_BIT | 32'd2;
    if (x == 32'd3) return FITS ? INIT_CHUNK : ALLOC_BIT;
    if (FITS && x == 32'd3 + INIT_CHUNK - 32'd1) return INIT_CHUNK;
    if (FITS && x == 32'd3 + INIT_CHUNK) return ALLOC_BIT;
    return 32'd0;
  endfunction

  assign in_req  = in_tdata[17:0];
  assign req15   = 19'(in_req) + 19'd15;
  assign need_in = (in_req <= 18'd8) ? MIN_NEED : {req15[18:3], 1'b0};

  assign rdata = oob_r ? 32'd0 : q_r;
  assign s     = rdata & SIZE_MASK;
  assign rfree = ~rdata[30];
  assign nh    = hdr_r + s;
  assign found = rfree && (32'(need_r) <= s);
  assign over  = (33'(hdr_r) + 33'(s)) > 33'(HEAP);

  assign gw  = (need_r > grow_r) ? need_r : grow_r;
  assign gw1 = 18'(gw) + 18'd1;
  assign w   = {gw1[17:1], 1'b0};

  assign free_bad = (baddr_r == 16'd0) || baddr_r[0] || (baddr_r < 16'd4) ||
                    (32'(baddr_r) >= 32'(bp_r));

  always_comb begin
    sts.clr_done  = clr_r == AW'(HEAP_WORDS - 1);
    sts.is_alloc  = ~act_r;
    sts.ign       = act_r ? free_bad : (req_r == 18'd0);
    sts.hdr_past  = hdr_r >= 32'(bp_r);
    sts.fit_fail  = (s == 32'd0) || (!found && (over || nh >= 32'(bp_r)));
    sts.fit_found = (s != 32'd0) && found;
    sts.grow_fail = (32'(bp_r) + 32'(w) > HEAP) || (bp_r == '0);
    sts.mg_none   = ~pf_r & ~rfree;
    sts.split     = (s >= 32'(need_r)) && ((s - 32'(need_r)) >= SPLIT_MIN);
    sts.out_free  = ~out_valid_r | out_tready;
  end

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = hdr_r;
    case (cmd.op)
      OP_FIT_RD, OP_MG0, OP_PL0, OP_FR0: rd_en = 1'b1;
      OP_FIT_EVAL: begin
        rd_en   = 1'b1;
        rd_addr = nh;
      end
      OP_MG1: begin
        rd_en   = 1'b1;
        rd_addr = hdr_r - 32'd1;
      end
      OP_MG2: begin
        rd_en   = 1'b1;
        rd_addr = hdr_r - s;
      end
      OP_MG3: begin
        rd_en   = 1'b1;
        rd_addr = hdr_r + size_r;
      end
      default: rd_en = 1'b0;
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = sb_addr_r;
    wr_data = sb_val_r;
    case (cmd.op)
      OP_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = 32'(clr_r);
        wr_data = init_word(clr_r);
      end
      OP_GROW_W0: begin
        wr_en   = 1'b1;
        wr_addr = hdr_r;
        wr_data = size_r;
      end
      OP_GROW_W1: begin
        wr_en   = 1'b1;
        wr_addr = hdr_r + size_r - 32'd1;
        wr_data = size_r;
      end
      OP_GROW_W2: begin
        wr_en   = 1'b1;
        wr_addr = hdr_r + size_r;
        wr_data = ALLOC_BIT;
      end
      OP_SB_H: wr_en = 1'b1;
      OP_SB_F: begin
        wr_en   = (sb_val_r & SIZE_MASK) != 32'd0;
        wr_addr = sb_addr_r + (sb_val_r & SIZE_MASK) - 32'd1;
      end
      default: wr_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en && wr_addr < HEAP) mem[wr_addr[AW-1:0]] <= wr_data;
    if (rd_en) begin
      oob_r <= rd_addr >= HEAP;
      if (rd_addr < HEAP) q_r <= mem[rd_addr[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r       <= '0;
      bp_r        <= BP_RESET;
      grow_r      <= GROW_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) grow_r <= cfg_data;
      if (cmd.op == OP_CLEAR) clr_r <= clr_r + AW'(1);
      if (cmd.op == OP_GROW_W2) bp_r <= bp_r + BW'(size_r);
      if (out_valid_r && out_tready) out_valid_r <= 1'b0;
      if (cmd.op == OP_FINISH && sts.out_free) out_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_IDLE: begin
        if (in_tvalid) begin
          act_r     <= in_tuser;
          req_r     <= in_req;
          baddr_r   <= in_tdata[33:18];
          need_r    <= need_in;
          res_pay_r <= 16'd0;
          res_st_r  <= RES_DONE;
        end
      end
      OP_DECODE: begin
        hdr_r <= act_r ? 32'(baddr_r) - 32'd1 : 32'd1;
        if (sts.ign) res_st_r <= RES_IGN;
      end
      OP_FIT_EVAL: begin
        if (!sts.fit_fail && !sts.fit_found) hdr_r <= nh;
      end
      OP_GROW: begin
        if (sts.grow_fail) begin
          res_st_r <= RES_NOSPC;
        end else begin
          hdr_r  <= 32'(bp_r) - 32'd1;
          size_r <= 32'(w);
        end
      end
      OP_MG1: size_r <= s;
      OP_MG2: prev_r <= hdr_r - s;
      OP_MG3: begin
        pf_r    <= rfree;
        psize_r <= s;
      end
      OP_MG4: begin
        if (!pf_r) begin
          sb_addr_r <= hdr_r;
          sb_val_r  <= (size_r + s) & SIZE_MASK;
        end else begin
          sb_addr_r <= prev_r;
          hdr_r     <= prev_r;
          sb_val_r  <= (size_r + psize_r + (rfree ? s : 32'd0)) & SIZE_MASK;
        end
      end
      OP_PL1: begin
        res_pay_r <= 16'(hdr_r + 32'd1);
        have_r    <= s;
        sb_addr_r <= hdr_r;
        sb_val_r  <= (sts.split ? 32'(need_r) : s) | ALLOC_BIT;
      end
      OP_PL2: begin
        sb_addr_r <= hdr_r + 32'(need_r);
        sb_val_r  <= (have_r - 32'(need_r)) & SIZE_MASK;
      end
      OP_FR1: begin
        sb_addr_r <= hdr_r;
        sb_val_r  <= s;
      end
      OP_FINISH: begin
        if (sts.out_free) begin
          out_pay_r <= res_pay_r;
          out_st_r  <= res_st_r;
        end
      end
      default: ;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_st_r, out_pay_r};

endmodule

### rtl/boundary_tag_heap_allocator_top.sv
// Operation: a free marks the block free and merges it with its free neighbours; an
//   allocate scans headers first-fit, splits the block when enough is left and grows
//   the heap when none fits, else reports no space; bad requests are ignored.
// Throughput: one request at a time, set by the single-port heap memory (one read or
//   one write per cycle); the next request is taken while a result waits.
// Reset: synchronous, active low; a pass over every heap word writes the initial heap
//   image before the first request is accepted.
module boundary_tag_heap_allocator_top #(
  parameter int unsigned HEAP_WORDS = 65536
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // request_bytes[17:0], block_addr[33:18]
  input  logic        in_tuser,   // action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // payload_addr[15:0], status[17:16]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [16:0] cfg_data    // grow_words
);
  import btha_pkg::*;

  cmd_t cmd;
  sts_t sts;

  btha_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .sts       (sts),
    .cmd       (cmd)
  );

  btha_dp #(
    .HEAP_WORDS (HEAP_WORDS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_tvalid  (in_tvalid),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .sts        (sts)
  );

  assign in_tready = cmd.op == OP_IDLE;
  assign cfg_ready = 1'b1;

endmodule
